FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the LRU buffer cache unit
// Entry count, field widths, command codes, controller states.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned EntW    = 5;
  localparam int unsigned RefMax  = 255;

  typedef enum logic [1:0] {
    CmdGet     = 2'd0,
    CmdRelease = 2'd1,
    CmdPin     = 2'd2,
    CmdUnpin   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StAdjRead,
    StAdjWrite,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear scan state
    logic scan;      // examine the entry at scan_idx
    logic decide;    // resolve a get after the scan
    logic adj_write; // apply release/pin/unpin
    logic [IdxW-1:0] scan_idx;
  } dp_cmd_t;

endpackage

FILE: rtl/lbc_datapath.sv
// ----------------------------------------------------------------------------
// lbc_datapath: entry table, scan registers and result register
// Scans one entry per cycle for tag match and oldest unreferenced entry.
// ----------------------------------------------------------------------------
module lbc_datapath import lbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  input  logic [1:0]      command_i,
  input  logic [31:0]     device_i,
  input  logic [31:0]     block_number_i,
  input  logic [EntW-1:0] entry_i,
  input  logic [31:0]     now_i,
  output logic [EntW-1:0] result_entry_o,
  output logic            was_cached_o,
  output logic            needs_fill_o,
  output logic            no_buffer_o
);

  logic [31:0] tdev_q [Entries];
  logic [31:0] tblk_q [Entries];
  logic        dval_q [Entries];
  logic [7:0]  rcnt_q [Entries];
  logic [31:0] lrel_q [Entries];
  logic [CntW-1:0] used_q;

  logic [1:0]  cmd_q;
  logic [31:0] dev_q, blk_q, now_q;
  logic [EntW-1:0] ent_q;

  logic            hit_q, fnd_q;
  logic [IdxW-1:0] hidx_q, pick_q;
  logic [31:0]     pold_q;

  logic [EntW-1:0] res_ent_q;
  logic            res_hit_q, res_fill_q, res_none_q;

  logic [IdxW-1:0] si;
  logic            in_use, match, cand;
  logic [IdxW-1:0] aidx;
  logic            avalid;

  assign si     = cmd_i.scan_idx;
  assign in_use = {{(32-CntW){1'b0}}, used_q} > 32'(si);
  assign match  = in_use && tdev_q[si] == dev_q && tblk_q[si] == blk_q;
  assign cand   = rcnt_q[si] == 8'd0 && (!fnd_q || lrel_q[si] < pold_q);
  assign aidx   = IdxW'(ent_q);
  assign avalid = {{(32-EntW){1'b0}}, ent_q} < {{(32-CntW){1'b0}}, used_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      dev_q <= device_i;
      blk_q <= block_number_i;
      ent_q <= entry_i;
      now_q <= now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      fnd_q  <= 1'b0;
      hidx_q <= '0;
      pick_q <= '0;
      pold_q <= '0;
      used_q <= '0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
      fnd_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (match && !hit_q) begin
        hit_q  <= 1'b1;
        hidx_q <= si;
      end
      if (cand) begin
        fnd_q  <= 1'b1;
        pick_q <= si;
        pold_q <= lrel_q[si];
      end
    end else if (cmd_i.decide && !hit_q && used_q < CntW'(Entries)) begin
      used_q <= used_q + 1'b1;
    end
  end

  // table writes and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_ent_q  <= '0;
      res_hit_q  <= 1'b0;
      res_fill_q <= 1'b0;
      res_none_q <= 1'b0;
    end else if (cmd_i.decide) begin
      if (hit_q) begin
        if (rcnt_q[hidx_q] != 8'(RefMax)) rcnt_q[hidx_q] <= rcnt_q[hidx_q] + 8'd1;
        dval_q[hidx_q] <= 1'b1;
        res_ent_q  <= EntW'(hidx_q);
        res_hit_q  <= 1'b1;
        res_fill_q <= !dval_q[hidx_q];
      end else if (used_q < CntW'(Entries)) begin
        tdev_q[IdxW'(used_q)] <= dev_q;
        tblk_q[IdxW'(used_q)] <= blk_q;
        rcnt_q[IdxW'(used_q)] <= 8'd1;
        dval_q[IdxW'(used_q)] <= 1'b1;
        res_ent_q  <= EntW'(used_q);
        res_fill_q <= 1'b1;
      end else if (fnd_q) begin
        tdev_q[pick_q] <= dev_q;
        tblk_q[pick_q] <= blk_q;
        rcnt_q[pick_q] <= 8'd1;
        dval_q[pick_q] <= 1'b1;
        res_ent_q  <= EntW'(pick_q);
        res_fill_q <= 1'b1;
      end else begin
        res_none_q <= 1'b1;
      end
    end else if (cmd_i.adj_write && avalid) begin
      case (cmd_e'(cmd_q))
        CmdRelease: begin
          if (rcnt_q[aidx] != 8'd0) begin
            rcnt_q[aidx] <= rcnt_q[aidx] - 8'd1;
            if (rcnt_q[aidx] == 8'd1) lrel_q[aidx] <= now_q;
          end
        end
        CmdPin: begin
          if (rcnt_q[aidx] != 8'(RefMax)) rcnt_q[aidx] <= rcnt_q[aidx] + 8'd1;
        end
        CmdUnpin: begin
          if (rcnt_q[aidx] != 8'd0) rcnt_q[aidx] <= rcnt_q[aidx] - 8'd1;
        end
        default: ;
      endcase
    end
  end

  assign result_entry_o = res_ent_q;
  assign was_cached_o   = res_hit_q;
  assign needs_fill_o   = res_fill_q;
  assign no_buffer_o    = res_none_q;

endmodule

FILE: rtl/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl: request sequencer of the LRU buffer cache unit
// Drives the entry scan, the get decision, count updates and the handshake.
// ----------------------------------------------------------------------------
module lbc_ctrl import lbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      StIdle: begin
        idx_d = '0;
        if (in_valid_i) state_d = (cmd_e'(command_i) == CmdGet) ? StScan : StAdjRead;
      end
      StScan: begin
        idx_d = idx_q + 1'b1;
        if ({{(32-IdxW){1'b0}}, idx_q} == Entries - 1) state_d = StDecide;
      end
      StDecide:   state_d = StOut;
      StAdjRead:  state_d = StAdjWrite;
      StAdjWrite: state_d = StOut;
      StOut:      if (out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o      = state_q == StIdle;
    out_valid_o     = state_q == StOut;
    cmd_o.load      = state_q == StIdle && in_valid_i;
    cmd_o.scan      = state_q == StScan;
    cmd_o.decide    = state_q == StDecide;
    cmd_o.adj_write = state_q == StAdjWrite;
    cmd_o.scan_idx  = idx_q;
  end

endmodule

FILE: rtl/lru_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: buffer cache tag table with global LRU reuse
//
//   channel | handshake             | payload
//   in      | in_valid_i/in_ready_o | command, device, block_number, entry, now
//   out     | out_valid_o/out_ready_i | result_entry, was_cached, needs_fill,
//           |                       |   no_buffer
//
// A get scans the table one entry per cycle, then passes through decide and
// result. Release, pin, unpin pass through adjust-read, adjust-write and result.
// Reset clears the fill count; no clearing pass. A stalled output holds the
// unit until the result is taken.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit import lbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [31:0]     device_i,
  input  logic [31:0]     block_number_i,
  input  logic [EntW-1:0] entry_i,
  input  logic [31:0]     now_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [EntW-1:0] result_entry_o,
  output logic            was_cached_o,
  output logic            needs_fill_o,
  output logic            no_buffer_o
);

  dp_cmd_t  dcmd;

  lbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
    .out_valid_o, .out_ready_i, .cmd_o(dcmd)
  );

  lbc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd),
    .command_i, .device_i, .block_number_i, .entry_i, .now_i,
    .result_entry_o, .was_cached_o, .needs_fill_o, .no_buffer_o
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: LRU buffer cache unit
// Directed table of requests, then random traffic, checked field by field
// against an in-bench model of the tag table, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import lbc_pkg::*;

  localparam int unsigned NumRandom = 1320;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [EntW-1:0] ent;
    logic            hit;
    logic            fill;
    logic            none;
  } outcome_t;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] dev;
    logic [31:0] blk;
    logic [4:0]  ent;
    logic [31:0] now;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] command_i = '0;
  logic [31:0] device_i = '0;
  logic [31:0] block_number_i = '0;
  logic [EntW-1:0] entry_i = '0;
  logic [31:0] now_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [EntW-1:0] result_entry_o;
  logic was_cached_o, needs_fill_o, no_buffer_o;

  lru_block_buffer_cache_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model of the tag table
  logic [31:0] m_dev [Entries];
  logic [31:0] m_blk [Entries];
  bit          m_valid [Entries];
  logic [7:0]  m_refs [Entries];
  logic [31:0] m_stamp [Entries];
  int unsigned m_used;

  outcome_t pending_q[$];
  int unsigned errors = 0;
  int unsigned sender_idle = 0, receiver_idle = 0;
  bit hold_off = 1'b0;
  int unsigned quiet = 0;

  function automatic outcome_t lookup_block(cmd_e cmd, logic [31:0] dev, logic [31:0] blk,
                                            logic [4:0] ent, logic [31:0] now);
    outcome_t o;
    int pick;
    o = '0;
    if (cmd == CmdGet) begin
      for (int i = 0; i < m_used; i++) begin
        if (m_dev[i] == dev && m_blk[i] == blk) begin
          if (m_refs[i] != 8'(RefMax)) m_refs[i]++;
          o.ent = EntW'(i);
          o.hit = 1'b1;
          o.fill = !m_valid[i];
          m_valid[i] = 1'b1;
          return o;
        end
      end
      pick = -1;
      if (m_used < Entries) begin
        pick = m_used;
        m_used++;
      end else begin
        for (int i = 0; i < Entries; i++)
          if (m_refs[i] == 0 && (pick < 0 || m_stamp[i] < m_stamp[pick])) pick = i;
      end
      if (pick < 0) begin
        o.none = 1'b1;
        return o;
      end
      m_dev[pick] = dev;
      m_blk[pick] = blk;
      m_refs[pick] = 8'd1;
      m_valid[pick] = 1'b1;
      o.ent = EntW'(pick);
      o.fill = 1'b1;
      return o;
    end
    if (ent >= m_used) return o;
    case (cmd)
      CmdRelease: if (m_refs[ent] != 0) begin
        m_refs[ent]--;
        if (m_refs[ent] == 0) m_stamp[ent] = now;
      end
      CmdPin: if (m_refs[ent] != 8'(RefMax)) m_refs[ent]++;
      default: if (m_refs[ent] != 0) m_refs[ent]--;
    endcase
    return o;
  endfunction

  // valid stays up between back-to-back requests; it drops only on a gap
  task automatic send_request(cmd_e cmd, logic [31:0] dev, logic [31:0] blk,
                              logic [4:0] ent, logic [31:0] now);
    int unsigned gap;
    gap = 0;
    if (sender_idle != 0)
      while ($urandom_range(99) < sender_idle && gap < 20) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        gap++;
      end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    device_i <= dev;
    block_number_i <= blk;
    entry_i <= ent;
    now_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(lookup_block(cmd, dev, blk, ent, now));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver
  always @(negedge clk_i)
    out_ready_i <= !hold_off && !(receiver_idle != 0 && $urandom_range(99) < receiver_idle);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        outcome_t w;
        w = pending_q.pop_front();
        if (result_entry_o !== w.ent) begin
          $error("result_entry expected %0d got %0d", w.ent, result_entry_o);
          errors++;
        end
        if (was_cached_o !== w.hit) begin
          $error("was_cached expected %0d got %0d", w.hit, was_cached_o);
          errors++;
        end
        if (needs_fill_o !== w.fill) begin
          $error("needs_fill expected %0d got %0d", w.fill, needs_fill_o);
          errors++;
        end
        if (no_buffer_o !== w.none) begin
          $error("no_buffer expected %0d got %0d", w.none, no_buffer_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(cmd_e c, logic [31:0] d, logic [31:0] b, logic [4:0] e,
                              logic [31:0] n, bit t = 0, outcome_t w = '0);
    row_t r;
    r.cmd = c; r.dev = d; r.blk = b; r.ent = e; r.now = n; r.typed = t; r.want = w;
    return r;
  endfunction

  // random request; small tag space so hits and reuse are frequent
  task automatic random_request();
    cmd_e c;
    logic [31:0] d, b;
    int unsigned sel;
    sel = $urandom_range(99);
    c = sel < 40 ? CmdGet : sel < 75 ? CmdRelease : sel < 88 ? CmdPin : CmdUnpin;
    if ($urandom_range(9) == 0) begin
      d = $urandom;
      b = $urandom;
    end else begin
      d = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'(($urandom_range(1)));
      b = {$urandom_range(1) ? 24'hFFFFFF : 24'h0, 8'($urandom_range(47))};
    end
    send_request(c, d, b, 5'($urandom_range(31)), $urandom);
  endtask

  initial begin
    for (int i = 0; i < Entries; i++) begin
      m_dev[i] = '0; m_blk[i] = '0; m_valid[i] = 0; m_refs[i] = '0; m_stamp[i] = '0;
    end
    m_used = 0;

    // unused entries ignored, then first fills, hits, saturation
    rows.push_back(mk(CmdRelease, 0, 0, 5'd0, 32'd5, 1, '0));
    rows.push_back(mk(CmdPin, 0, 0, 5'd31, 0, 1, '0));
    rows.push_back(mk(CmdGet, 32'h0, 32'h0, 0, 0, 1, '{ent: 5'd0, hit: 0, fill: 1, none: 0}));
    rows.push_back(mk(CmdGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1,
                      '{ent: 5'd1, hit: 0, fill: 1, none: 0}));
    rows.push_back(mk(CmdGet, 32'h0, 32'h0, 0, 0, 1, '{ent: 5'd0, hit: 1, fill: 0, none: 0}));
    rows.push_back(mk(CmdUnpin, 0, 0, 5'd1, 32'd9));
    rows.push_back(mk(CmdRelease, 0, 0, 5'd1, 32'd9));
    rows.push_back(mk(CmdRelease, 0, 0, 5'd0, 32'hFFFF_FFFF));
    rows.push_back(mk(CmdRelease, 0, 0, 5'd0, 32'hFFFF_FFFF));
    rows.push_back(mk(CmdRelease, 0, 0, 5'd0, 32'd3));
    rows.push_back(mk(CmdUnpin, 0, 0, 5'd2, 0));
    rows.push_back(mk(CmdGet, 32'hFFFF_FFFF, 32'h0, 0, 0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      send_request(rows[k].cmd, rows[k].dev, rows[k].blk, rows[k].ent, rows[k].now);
      if (rows[k].typed && pending_q[$] != rows[k].want) begin
        $error("table row %0d: model gives %p, row gives %p", k, pending_q[$], rows[k].want);
        errors++;
      end
    end
    // saturate entry 0 at the top, then fill the table so a full table is reached
    repeat (260) send_request(CmdPin, 0, 0, 5'd0, 0);
    send_request(CmdGet, 32'h0, 32'h0, 0, 0);
    for (int i = 0; i < 34; i++) send_request(CmdGet, 32'd7, 32'(i), 0, 0);
    // all referenced: no buffer
    send_request(CmdGet, 32'd9, 32'd9, 0, 0);
    // equal ticks: release two with same stamp, lowest wins
    send_request(CmdRelease, 0, 0, 5'd9, 32'd100);
    send_request(CmdRelease, 0, 0, 5'd4, 32'd100);
    send_request(CmdGet, 32'd9, 32'd9, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle = ph == 1 ? 77 : ph == 3 ? 37 : 0;
      receiver_idle = ph == 2 ? 77 : ph == 3 ? 37 : 0;
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk_i);
            hold_off = 1'b0;
          end
          repeat (20) random_request();
        join
      end
      repeat (NumRandom / 4) random_request();
      drain();
    end
    sender_idle = 0;
    receiver_idle = 0;
    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: lru_block_buffer_cache_unit.f
rtl/lbc_pkg.sv
rtl/lbc_datapath.sv
rtl/lbc_ctrl.sv
rtl/lru_block_buffer_cache_unit.sv
tb/testbench.sv
